### rtl/core/rgbs_pkg.sv
// Shared types and constants for the RGB saturation setter.
// Used by rgbs_front, rgbs_fifo, rgbs_back and rgb_saturation_set_hsv.
// No dependencies.
package rgbs_pkg;

   // Channel width and derived widths
   localparam int PIX_W       = 8;
   localparam int PROD_W      = 2 * PIX_W;
   localparam int DIV_STEPS   = PIX_W;
   localparam int QUEUE_DEPTH = 4;

   // Reset value of the saturation register (full saturation)
   localparam logic [PIX_W-1:0] SAT_RESET = PIX_W'(255);

   // Role of each channel in the result
   typedef enum logic [1:0] {
      ROLE_HI  = 2'b00,   // channel becomes v
      ROLE_LO  = 2'b01,   // channel becomes v - C
      ROLE_MID = 2'b10    // channel becomes v - C + C*offset/delta
   } role_type;

   // Classified pixel travelling from the front part to the back part.
   // roles[0] is red, roles[1] green, roles[2] blue.
   typedef struct packed {
      logic [PIX_W-1:0] v;
      logic [PIX_W-1:0] delta;
      logic [PIX_W-1:0] offset;
      role_type [2:0]   roles;
   } item_type;

endpackage

### rtl/core/rgbs_front.sv
// Front part: accepts pixels, finds max, min and median, assigns roles.
// Depends on rgbs_pkg.
// Holds one classified item until the queue takes it.
module rgbs_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [rgbs_pkg::PIX_W-1:0] red_in,
   input  logic [rgbs_pkg::PIX_W-1:0] green_in,
   input  logic [rgbs_pkg::PIX_W-1:0] blue_in,
   output logic                      q_valid,
   input  logic                      q_ready,
   output rgbs_pkg::item_type        q_item
);

   logic                              fr_valid_ff, fr_valid_in;
   rgbs_pkg::item_type                fr_item_ff, fr_item_in;
   logic [rgbs_pkg::PIX_W-1:0]        v_max, v_min, v_med;
   logic [rgbs_pkg::PIX_W+1:0]        ch_sum;
   logic                              gray;
   logic [rgbs_pkg::PIX_W-1:0]        chans [3];

   assign chans[0] = red_in;
   assign chans[1] = green_in;
   assign chans[2] = blue_in;

   // Take a new pixel when the holding register is empty or draining
   assign req_ready = !fr_valid_ff || q_ready;
   assign q_valid   = fr_valid_ff;
   assign q_item    = fr_item_ff;

   // Classify the incoming pixel
   always_comb begin
      v_max = (red_in > green_in) ? red_in : green_in;
      v_max = (v_max > blue_in) ? v_max : blue_in;
      v_min = (red_in < green_in) ? red_in : green_in;
      v_min = (v_min < blue_in) ? v_min : blue_in;
      ch_sum = {2'b00, red_in} + {2'b00, green_in} + {2'b00, blue_in};
      v_med  = rgbs_pkg::PIX_W'(ch_sum - {2'b00, v_max} - {2'b00, v_min});
      gray   = (v_max == v_min);

      fr_item_in.v      = v_max;
      fr_item_in.delta  = v_max - v_min;
      fr_item_in.offset = v_med - v_min;
      for (int i = 0; i < 3; i++) begin
         priority if (gray) begin
            fr_item_in.roles[i] = (i == 0) ? rgbs_pkg::ROLE_HI : rgbs_pkg::ROLE_LO;
         end else if (chans[i] == v_max) begin
            fr_item_in.roles[i] = rgbs_pkg::ROLE_HI;
         end else if (chans[i] == v_min) begin
            fr_item_in.roles[i] = rgbs_pkg::ROLE_LO;
         end else begin
            fr_item_in.roles[i] = rgbs_pkg::ROLE_MID;
         end
      end
   end

   // Hold the item until the queue takes it
   always_comb begin
      fr_valid_in = fr_valid_ff;
      if (req_valid && req_ready) begin
         fr_valid_in = 1'b1;
      end else if (q_ready) begin
         fr_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         fr_item_ff <= fr_item_in;
      end
   end

   // A stalled item stays put
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      fr_valid_ff && !q_ready |=> fr_valid_ff && $stable(fr_item_ff))
      else $error("front item changed while the queue was full");

endmodule

### rtl/core/rgbs_fifo.sv
// Short queue between the front and back parts, show-ahead.
// Depends on rgbs_pkg for the item type.
// Entries are plain registers; the head is read combinationally.
module rgbs_fifo #(
   parameter int DEPTH = rgbs_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  rgbs_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output rgbs_pkg::item_type pop_item
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rgbs_pkg::item_type entry_ff [DEPTH];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue occupancy beyond its depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue occupancy did not grow on a lone push");

endmodule

### rtl/core/rgbs_back.sv
// Back part: computes C = v*sat/255, then C*offset/delta in a bit-per-stage
// restoring divider, then forms the three output channels.
// Depends on rgbs_pkg. All stages advance together when the output can move.
module rgbs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [rgbs_pkg::PIX_W-1:0] sat,
   input  logic                       q_valid,
   output logic                       q_ready,
   input  rgbs_pkg::item_type         q_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [rgbs_pkg::PIX_W-1:0] red_out,
   output logic [rgbs_pkg::PIX_W-1:0] green_out,
   output logic [rgbs_pkg::PIX_W-1:0] blue_out
);

   localparam int W  = rgbs_pkg::PIX_W;
   localparam int PW = rgbs_pkg::PROD_W;
   localparam int NS = rgbs_pkg::DIV_STEPS;

   logic                 en;

   // Stage 1: product v*sat
   logic                 s1_vld_ff;
   logic [PW-1:0]        s1_prod_ff;
   rgbs_pkg::item_type   s1_item_ff;

   // Stage 2: C
   logic                 s2_vld_ff;
   logic [W-1:0]         s2_c_ff, s2_c_in;
   rgbs_pkg::item_type   s2_item_ff;
   logic [PW:0]          c_est;
   logic [W:0]           c_q0;
   logic [PW:0]          c_back, c_rem;

   // Divider stages; index 0 holds the numerator C*offset
   logic                 dv_vld_ff   [NS+1];
   logic [W-1:0]         dv_rem_ff   [NS+1];
   logic [W-1:0]         dv_rem_in   [NS+1];
   logic [W-1:0]         dv_low_ff   [NS+1];
   logic [W-1:0]         dv_low_in   [NS+1];
   logic [W-1:0]         dv_quo_ff   [NS+1];
   logic [W-1:0]         dv_quo_in   [NS+1];
   logic [W-1:0]         dv_v_ff     [NS+1];
   logic [W-1:0]         dv_c_ff     [NS+1];
   logic [W-1:0]         dv_delta_ff [NS+1];
   rgbs_pkg::role_type [2:0] dv_role_ff [NS+1];
   logic [PW-1:0]        num;
   logic [W:0]           shifted [NS+1];
   logic                 take    [NS+1];

   // Output register
   logic                 out_vld_ff;
   logic [W-1:0]         out_ch_ff [3];
   logic [W-1:0]         out_ch_in [3];
   logic [W-1:0]         lo_val, mid_val;

   // Move the whole pipeline when the output is free or being taken
   assign en      = !out_vld_ff || rsp_ready;
   assign q_ready = en;

   // C = floor(p/255): reciprocal estimate, then one correction
   always_comb begin
      c_est  = {1'b0, s1_prod_ff} + {(PW+1-W)'(0), s1_prod_ff[PW-1:W]};
      c_q0   = c_est[PW:W];
      c_back = {c_q0, (W)'(0)} - {(PW-W)'(0), c_q0};
      c_rem  = {1'b0, s1_prod_ff} - c_back;
      if (c_rem >= (PW+1)'(255)) begin
         s2_c_in = W'(c_q0 + 1'b1);
      end else begin
         s2_c_in = W'(c_q0);
      end
   end

   // Numerator and one restoring step per divider stage
   always_comb begin
      num          = PW'(s2_c_ff) * PW'(s2_item_ff.offset);
      dv_rem_in[0] = num[PW-1:W];
      dv_low_in[0] = num[W-1:0];
      dv_quo_in[0] = '0;
      shifted[0]   = '0;
      take[0]      = 1'b0;
      for (int k = 1; k <= NS; k++) begin
         shifted[k] = {dv_rem_ff[k-1], dv_low_ff[k-1][W-1]};
         take[k]    = (shifted[k] >= {1'b0, dv_delta_ff[k-1]});
         dv_rem_in[k] = take[k] ? W'(shifted[k] - {1'b0, dv_delta_ff[k-1]})
                                : W'(shifted[k]);
         dv_low_in[k] = {dv_low_ff[k-1][W-2:0], 1'b0};
         dv_quo_in[k] = {dv_quo_ff[k-1][W-2:0], take[k]};
      end
   end

   // Form the output channels from their roles
   always_comb begin
      lo_val  = dv_v_ff[NS] - dv_c_ff[NS];
      mid_val = lo_val + dv_quo_ff[NS];
      for (int i = 0; i < 3; i++) begin
         unique case (dv_role_ff[NS][i])
            rgbs_pkg::ROLE_HI:  out_ch_in[i] = dv_v_ff[NS];
            rgbs_pkg::ROLE_LO:  out_ch_in[i] = lo_val;
            rgbs_pkg::ROLE_MID: out_ch_in[i] = mid_val;
            default:            out_ch_in[i] = lo_val;
         endcase
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int k = 0; k <= NS; k++) begin
            dv_vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         s1_vld_ff    <= q_valid;
         s2_vld_ff    <= s1_vld_ff;
         dv_vld_ff[0] <= s2_vld_ff;
         for (int k = 1; k <= NS; k++) begin
            dv_vld_ff[k] <= dv_vld_ff[k-1];
         end
         out_vld_ff <= dv_vld_ff[NS];
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff <= PW'(q_item.v) * PW'(sat);
         s1_item_ff <= q_item;
         s2_c_ff    <= s2_c_in;
         s2_item_ff <= s1_item_ff;
         dv_rem_ff[0]   <= dv_rem_in[0];
         dv_low_ff[0]   <= dv_low_in[0];
         dv_quo_ff[0]   <= dv_quo_in[0];
         dv_v_ff[0]     <= s2_item_ff.v;
         dv_c_ff[0]     <= s2_c_ff;
         dv_delta_ff[0] <= s2_item_ff.delta;
         dv_role_ff[0]  <= s2_item_ff.roles;
         for (int k = 1; k <= NS; k++) begin
            dv_rem_ff[k]   <= dv_rem_in[k];
            dv_low_ff[k]   <= dv_low_in[k];
            dv_quo_ff[k]   <= dv_quo_in[k];
            dv_v_ff[k]     <= dv_v_ff[k-1];
            dv_c_ff[k]     <= dv_c_ff[k-1];
            dv_delta_ff[k] <= dv_delta_ff[k-1];
            dv_role_ff[k]  <= dv_role_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            out_ch_ff[i] <= out_ch_in[i];
         end
      end
   end

   assign rsp_valid = out_vld_ff;
   assign red_out   = out_ch_ff[0];
   assign green_out = out_ch_ff[1];
   assign blue_out  = out_ch_ff[2];

   // C never exceeds the value channel
   a_c_bound: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> s2_c_ff <= s2_item_ff.v)
      else $error("saturation chroma above value");

   // A middle channel's share never exceeds C
   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[NS] && (dv_role_ff[NS][0] == rgbs_pkg::ROLE_MID
                     || dv_role_ff[NS][1] == rgbs_pkg::ROLE_MID
                     || dv_role_ff[NS][2] == rgbs_pkg::ROLE_MID)
      |-> dv_quo_ff[NS] <= dv_c_ff[NS])
      else $error("divider quotient above chroma");

   // A pipeline stall freezes the stage occupancy
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(s1_vld_ff) && $stable(s2_vld_ff) && $stable(dv_vld_ff[NS]))
      else $error("back pipeline moved during a stall");

endmodule

### rtl/core/rgb_saturation_set_hsv.sv
// RGB saturation setter, top level: front classifier, queue, back pipeline.
// Throughput: one pixel per cycle while the output is not stalled; the back
// pipeline (product, C, 8-step divider, output register) advances whenever
// the output register can move.
// Reset (synchronous, active high) empties all stages and the queue and sets
// the saturation register to 255.
module rgb_saturation_set_hsv #(
   parameter int QUEUE_DEPTH = rgbs_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [rgbs_pkg::PIX_W-1:0] req_red_in,
   input  logic [rgbs_pkg::PIX_W-1:0] req_green_in,
   input  logic [rgbs_pkg::PIX_W-1:0] req_blue_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [rgbs_pkg::PIX_W-1:0] rsp_red_out,
   output logic [rgbs_pkg::PIX_W-1:0] rsp_green_out,
   output logic [rgbs_pkg::PIX_W-1:0] rsp_blue_out,
   input  logic                       csr_wr_en,
   input  logic [rgbs_pkg::PIX_W-1:0] csr_wr_data
);

   logic [rgbs_pkg::PIX_W-1:0] sat_ff;
   logic                       fq_valid, fq_ready;
   rgbs_pkg::item_type         fq_item;
   logic                       qb_valid, qb_ready;
   rgbs_pkg::item_type         qb_item;

   // Saturation register
   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff <= rgbs_pkg::SAT_RESET;
      end else if (csr_wr_en) begin
         sat_ff <= csr_wr_data;
      end
   end

   rgbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .red_in    (req_red_in),
      .green_in  (req_green_in),
      .blue_in   (req_blue_in),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_item    (fq_item)
   );

   rgbs_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_item   (qb_item)
   );

   rgbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .sat       (sat_ff),
      .q_valid   (qb_valid),
      .q_ready   (qb_ready),
      .q_item    (qb_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .red_out   (rsp_red_out),
      .green_out (rsp_green_out),
      .blue_out  (rsp_blue_out)
   );

endmodule
